### src/wpseq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpseq_pkg
// Shared constants and types of the waypoint sequencer: command codes,
// register indexes, reset values, field widths and the link between the
// sequencer and its distance unit.
// ----------------------------------------------------------------------------
package wpseq_pkg;

  // defaults of the top-level parameters
  localparam int MAX_WAYPOINTS_DEF = 16;
  localparam int POS_BITS_DEF      = 24;

  // fixed field widths
  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 4;
  localparam int RADIUS_W = 16;
  localparam int CLIMB_W  = 24;
  localparam int LEN_W    = 5;
  localparam int WPIDX_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  // wide enough to hold table depths up to 511 for compares
  localparam int DEPTH_W  = 9;
  // squares of values below 2^RADIUS_W and a sum of three of them
  localparam int SQ_W     = 2 * RADIUS_W;
  localparam int ACC_W    = SQ_W + 2;

  // commands
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POS   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIMB   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REQ     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANLEN = 2'd3;

  // configuration reset values
  localparam logic [RADIUS_W-1:0]       RADIUS_RST  = 16'd100;
  localparam logic signed [CLIMB_W-1:0] CLIMB_RST   = 24'sd1000;
  localparam logic                      REQ_RST     = 1'b1;
  localparam logic [LEN_W-1:0]          PLANLEN_RST = 5'd0;

  localparam logic [WPIDX_W-1:0] WPIDX_NONE = 5'h1F;

  // sequencer to distance unit
  typedef struct packed {
    logic       clear;       // first step of a new distance
    logic       diff_en;     // take |a - b| of the selected axis
    logic       acc_en;      // add the square of the held difference
    logic       sel_radius;  // square the radius instead
  } dist_ctrl_t;

  // distance unit to sequencer
  typedef struct packed {
    logic far;   // some axis difference reached the radius
    logic hit;   // valid while sel_radius: strictly inside the sphere
  } dist_stat_t;

endpackage
`default_nettype wire

### src/wpseq_dist.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpseq_dist
// Squared-distance unit: one subtractor and one 16x16 multiplier, stepped
// axis by axis by the sequencer, then reused to square the radius.
// ----------------------------------------------------------------------------
module wpseq_dist #(
  parameter int POS_BITS = wpseq_pkg::POS_BITS_DEF
) (
  input  wire                             clk,
  input  wpseq_pkg::dist_ctrl_t           ctrl,
  input  wire  signed [POS_BITS-1:0]      a,
  input  wire  signed [POS_BITS-1:0]      b,
  input  wire  [wpseq_pkg::RADIUS_W-1:0]  radius,
  output wpseq_pkg::dist_stat_t           stat
);
  import wpseq_pkg::*;

  localparam int DIFF_W = POS_BITS + 1;
  localparam int DW     = (DIFF_W > RADIUS_W) ? DIFF_W : RADIUS_W;

  logic signed [DIFF_W-1:0] diff;
  logic        [DIFF_W-1:0] diff_abs;
  logic        [DW-1:0]     abs_ext;
  logic        [DW-1:0]     radius_ext;
  logic        [DW-1:0]     d;
  logic        [RADIUS_W-1:0] mul_op;
  logic        [SQ_W-1:0]   sq;
  logic        [ACC_W-1:0]  acc;
  logic                     far;

  assign diff       = $signed({a[POS_BITS-1], a}) - $signed({b[POS_BITS-1], b});
  assign diff_abs   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign abs_ext    = DW'(diff_abs);
  assign radius_ext = DW'(radius);

  // only meaningful when no axis reached the radius, so the low bits suffice
  assign mul_op = ctrl.sel_radius ? radius : d[RADIUS_W-1:0];
  assign sq     = SQ_W'(mul_op) * SQ_W'(mul_op);

  always_ff @(posedge clk) begin
    if (ctrl.diff_en) begin
      d   <= abs_ext;
      far <= (far & ~ctrl.clear) | (abs_ext >= radius_ext);
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + ACC_W'(sq);
    end
  end

  assign stat.far = far;
  assign stat.hit = ~far && (acc < ACC_W'(sq));

endmodule
`default_nettype wire

### src/waypoint_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// waypoint_sequencer
// Acceptance-radius waypoint sequencer with a stored plan table.
// ----------------------------------------------------------------------------
// Every input transaction gives exactly one result transaction. Load, stop,
// a failed or climb start and a position update while inactive go from the
// execute state straight to the result state; a start that targets waypoint
// 0 first passes the table read and load states; a position update while
// active first runs the four steps of the shared subtract and multiply unit
// and the radius compare, then the registered table read and load when the target moves on.
// The input side is ready again the cycle after a result is registered,
// while that result waits on the output register. cmd travels in s_tuser;
// the result flags sit in m_tdata next to the target.
module waypoint_sequencer #(
  parameter int MAX_WAYPOINTS = wpseq_pkg::MAX_WAYPOINTS_DEF,
  parameter int POS_BITS      = wpseq_pkg::POS_BITS_DEF,
  localparam int IN_W  = ((wpseq_pkg::SLOT_W + 3 * POS_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((1 + 3 * POS_BITS + wpseq_pkg::WPIDX_W + 3 + 7) / 8) * 8
) (
  input  wire                               clk,
  input  wire                               rst,
  // configuration write channel
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [wpseq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [wpseq_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  wire                               s_tvalid,
  output logic                              s_tready,
  input  wire  [IN_W-1:0]                   s_tdata,  // slot, pos_x, pos_y, pos_z, zero pad
  input  wire  [wpseq_pkg::CMD_W-1:0]       s_tuser,  // cmd
  // result stream
  output logic                              m_tvalid,
  input  wire                               m_tready,
  // nav_active, target_x, target_y, target_z, waypoint_index,
  // reset_integral, plan_complete, start_failed, zero pad
  output logic [OUT_W-1:0]                  m_tdata
);
  import wpseq_pkg::*;

  localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int ENTRY_W = 3 * POS_BITS;
  localparam logic [DEPTH_W-1:0] DEPTH = DEPTH_W'(MAX_WAYPOINTS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_DIFF = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_LD   = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  // configuration
  logic [RADIUS_W-1:0]       acceptance_radius;
  logic signed [CLIMB_W-1:0] climb_altitude;
  logic                      require_climb;
  logic [LEN_W-1:0]          plan_length;

  // sequencer state
  logic [2:0]                state;
  logic [1:0]                step;
  logic                      active;
  logic                      climb_done;
  logic [WPIDX_W-1:0]        current_index;
  logic signed [POS_BITS-1:0] goal_x, goal_y, goal_z;
  logic                      pulse_int, pulse_done, pulse_fail;

  // held input transaction
  logic [CMD_W-1:0]          cmd;
  logic [SLOT_W-1:0]         slot;
  logic signed [POS_BITS-1:0] pos_x, pos_y, pos_z;

  // plan table
  logic [ENTRY_W-1:0]        mem [MAX_WAYPOINTS];
  logic [ENTRY_W-1:0]        mem_q;
  logic [AW-1:0]             rd_addr;
  logic                      mem_we;
  logic                      slot_ok;

  logic [LEN_W-1:0]          len;
  logic [WPIDX_W-1:0]        idx_inc;

  dist_ctrl_t                dctrl;
  dist_stat_t                dstat;
  logic signed [POS_BITS-1:0] op_a, op_b;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);

  // plan length above the table depth counts as the depth
  assign len = ({{(DEPTH_W-LEN_W){1'b0}}, plan_length} > DEPTH) ?
               LEN_W'(MAX_WAYPOINTS) : plan_length;
  assign idx_inc = current_index + WPIDX_W'(1);
  assign slot_ok = ({{(DEPTH_W-SLOT_W){1'b0}}, slot} < DEPTH);
  assign mem_we  = (state == ST_EXEC) && (cmd == CMD_LOAD) && slot_ok;

  // distance unit sequencing: diff x | diff y, sq x | diff z, sq y | sq z
  always_comb begin
    dctrl = '0;
    if (state == ST_DIFF) begin
      dctrl.clear   = (step == 2'd0);
      dctrl.diff_en = (step != 2'd3);
      dctrl.acc_en  = (step != 2'd0);
    end
    dctrl.sel_radius = (state == ST_CMP);
  end

  always_comb begin
    unique case (step)
      2'd0:    begin op_a = pos_x; op_b = goal_x; end
      2'd1:    begin op_a = pos_y; op_b = goal_y; end
      default: begin op_a = pos_z; op_b = goal_z; end
    endcase
  end

  wpseq_dist #(
    .POS_BITS (POS_BITS)
  ) u_dist (
    .clk    (clk),
    .ctrl   (dctrl),
    .a      (op_a),
    .b      (op_b),
    .radius (acceptance_radius),
    .stat   (dstat)
  );

  // table write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(slot)] <= {pos_z, pos_y, pos_x};
    end
    if (state == ST_RD) begin
      mem_q <= mem[rd_addr];
    end
  end

  // hold the accepted transaction
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd   <= s_tuser;
      slot  <= s_tdata[SLOT_W-1:0];
      pos_x <= s_tdata[SLOT_W +: POS_BITS];
      pos_y <= s_tdata[SLOT_W + POS_BITS +: POS_BITS];
      pos_z <= s_tdata[SLOT_W + 2 * POS_BITS +: POS_BITS];
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= OUT_W'({pulse_fail, pulse_done, pulse_int,
                         active ? current_index : WPIDX_NONE,
                         active ? goal_z : POS_BITS'(0),
                         active ? goal_y : POS_BITS'(0),
                         active ? goal_x : POS_BITS'(0),
                         active});
    end
  end

  // result valid: load when the output register is free, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acceptance_radius <= RADIUS_RST;
      climb_altitude    <= CLIMB_RST;
      require_climb     <= REQ_RST;
      plan_length       <= PLANLEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RADIUS:  acceptance_radius <= cfg_data[RADIUS_W-1:0];
        REG_CLIMB:   climb_altitude    <= cfg_data[CLIMB_W-1:0];
        REG_REQ:     require_climb     <= cfg_data[0];
        REG_PLANLEN: plan_length       <= cfg_data[LEN_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      active        <= 1'b0;
      climb_done    <= 1'b0;
      current_index <= '0;
      goal_x        <= '0;
      goal_y        <= '0;
      goal_z        <= '0;
      pulse_int     <= 1'b0;
      pulse_done    <= 1'b0;
      pulse_fail    <= 1'b0;
      rd_addr       <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            pulse_int  <= 1'b0;
            pulse_done <= 1'b0;
            pulse_fail <= 1'b0;
            state      <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          unique case (cmd)
            CMD_LOAD: begin
              state <= ST_DONE;
            end
            CMD_START: begin
              if (len == '0) begin
                active        <= 1'b0;
                climb_done    <= 1'b0;
                current_index <= '0;
                goal_x        <= '0;
                goal_y        <= '0;
                goal_z        <= '0;
                pulse_fail    <= 1'b1;
                state         <= ST_DONE;
              end else begin
                active        <= 1'b1;
                current_index <= '0;
                climb_done    <= ~require_climb;
                if (require_climb) begin
                  goal_x <= pos_x;
                  goal_y <= pos_y;
                  goal_z <= POS_BITS'(climb_altitude);
                  state  <= ST_DONE;
                end else begin
                  rd_addr <= '0;
                  state   <= ST_RD;
                end
              end
            end
            CMD_POS: begin
              if (active) begin
                step  <= '0;
                state <= ST_DIFF;
              end else begin
                state <= ST_DONE;
              end
            end
            CMD_STOP: begin
              active        <= 1'b0;
              climb_done    <= 1'b0;
              current_index <= '0;
              goal_x        <= '0;
              goal_y        <= '0;
              goal_z        <= '0;
              state         <= ST_DONE;
            end
          endcase
        end
        ST_DIFF: begin
          step <= step + 2'd1;
          if (step == 2'd3) begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (dstat.hit) begin
            if (!climb_done && require_climb) begin
              current_index <= '0;
              if (len != '0) begin
                climb_done <= 1'b1;
                rd_addr    <= '0;
                pulse_int  <= 1'b1;
                state      <= ST_RD;
              end else begin
                active     <= 1'b0;
                climb_done <= 1'b0;
                goal_x     <= '0;
                goal_y     <= '0;
                goal_z     <= '0;
                state      <= ST_DONE;
              end
            end else if (idx_inc < len) begin
              current_index <= idx_inc;
              rd_addr       <= AW'(idx_inc);
              pulse_int     <= 1'b1;
              state         <= ST_RD;
            end else begin
              // last waypoint reached
              active        <= 1'b0;
              climb_done    <= 1'b0;
              current_index <= '0;
              goal_x        <= '0;
              goal_y        <= '0;
              goal_z        <= '0;
              pulse_done    <= 1'b1;
              state         <= ST_DONE;
            end
          end else begin
            state <= ST_DONE;
          end
        end
        ST_RD: begin
          state <= ST_LD;
        end
        ST_LD: begin
          goal_x <= mem_q[0 +: POS_BITS];
          goal_y <= mem_q[POS_BITS +: POS_BITS];
          goal_z <= mem_q[2 * POS_BITS +: POS_BITS];
          state  <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: waypoint sequencer testbench
// Drives load, start, position and stop transactions into the sequencer
// with random gaps and output stalls. A scripted opening covers reset
// state, field extremes and the plan corner cases. Random phases with new
// register settings follow. Every result is checked field by field against
// a behavioral copy of the sequencer kept in this file or a literal expected result.
// ----------------------------------------------------------------------------
module tb_top;
  import wpseq_pkg::*;

  localparam int IN_W        = 80;
  localparam int OUT_W       = 88;
  localparam int ITEM_TARGET = 1550;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 12;
  localparam int LIMIT       = 250000;

  typedef logic signed [23:0] pos_t;

  localparam pos_t MAX_POS = 24'h7FFFFF;
  localparam pos_t MIN_POS = 24'h800000;

  // slot, x, y, z from the lowest bit up
  typedef struct packed {
    pos_t       z;
    pos_t       y;
    pos_t       x;
    logic [3:0] slot;
  } nav_item_t;

  // nav_active, target x/y/z, waypoint index, flags from the lowest bit up
  typedef struct packed {
    logic              fail;
    logic              done;
    logic              rint;
    logic signed [4:0] idx;
    pos_t              tz;
    pos_t              ty;
    pos_t              tx;
    logic              act;
  } nav_result_t;

  localparam nav_result_t IDLE_NAV = {3'b000, WPIDX_NONE, 72'd0, 1'b0};
  localparam nav_result_t FAIL_NAV = {3'b100, WPIDX_NONE, 72'd0, 1'b0};
  localparam nav_result_t DONE_NAV = {3'b010, WPIDX_NONE, 72'd0, 1'b0};

  typedef struct {
    logic                  is_reg;
    logic [CFG_IDX_W-1:0]  reg_sel;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [CMD_W-1:0]      cmd;
    nav_item_t             item;
    logic                  has_lit;
    nav_result_t           lit;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  logic [CMD_W-1:0]      s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;

  // sequencer image: table, navigation state, registers
  pos_t            wp_x [16];
  pos_t            wp_y [16];
  pos_t            wp_z [16];
  logic            nav_on = 1'b0;
  logic            climb_ok = 1'b0;
  logic [4:0]      wp_idx = '0;
  pos_t            aim_x = '0;
  pos_t            aim_y = '0;
  pos_t            aim_z = '0;
  logic [15:0]     cfg_radius = RADIUS_RST;
  pos_t            cfg_climb = CLIMB_RST;
  logic            cfg_req = REQ_RST;
  logic [4:0]      cfg_len = PLANLEN_RST;

  nav_result_t     pending_navs [$];
  script_row_t     script [$];
  int              errors = 0;
  int              items_sent = 0;
  int              cycle_count = 0;
  logic            tx_steady = 1'b0;
  logic            rx_steady = 1'b0;
  logic            long_hold = 1'b0;

  waypoint_sequencer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic void drop_nav();
    nav_on   = 1'b0;
    climb_ok = 1'b0;
    wp_idx   = '0;
    aim_x    = '0;
    aim_y    = '0;
    aim_z    = '0;
  endfunction

  function automatic void aim_at(logic [4:0] i);
    aim_x = wp_x[i[3:0]];
    aim_y = wp_y[i[3:0]];
    aim_z = wp_z[i[3:0]];
  endfunction

  // any axis at or beyond the radius is a miss before squaring
  function automatic logic in_sphere(pos_t x, pos_t y, pos_t z);
    longint r, dx, dy, dz;
    r  = cfg_radius;
    dx = longint'(x) - longint'(aim_x);
    dy = longint'(y) - longint'(aim_y);
    dz = longint'(z) - longint'(aim_z);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dz < 0) dz = -dz;
    if (dx >= r || dy >= r || dz >= r) return 1'b0;
    return (dx * dx + dy * dy + dz * dz) < r * r;
  endfunction

  function automatic nav_result_t advance_nav(logic [CMD_W-1:0] c, nav_item_t it);
    nav_result_t r;
    logic [4:0]  len;
    r   = '0;
    len = (cfg_len > 5'd16) ? 5'd16 : cfg_len;
    case (c)
      CMD_LOAD: begin
        wp_x[it.slot] = it.x;
        wp_y[it.slot] = it.y;
        wp_z[it.slot] = it.z;
      end
      CMD_START: begin
        if (len == 0) begin
          drop_nav();
          r.fail = 1'b1;
        end else begin
          nav_on   = 1'b1;
          wp_idx   = '0;
          climb_ok = !cfg_req;
          if (!climb_ok) begin
            aim_x = it.x;
            aim_y = it.y;
            aim_z = cfg_climb;
          end else begin
            aim_at(5'd0);
          end
        end
      end
      CMD_POS: begin
        if (nav_on && in_sphere(it.x, it.y, it.z)) begin
          if (!climb_ok && cfg_req) begin
            climb_ok = 1'b1;
            wp_idx   = '0;
            if (len > 0) begin
              aim_at(5'd0);
              r.rint = 1'b1;
            end else begin
              drop_nav();
            end
          end else begin
            wp_idx = wp_idx + 5'd1;
            if (wp_idx < len) begin
              aim_at(wp_idx);
              r.rint = 1'b1;
            end else begin
              drop_nav();
              r.done = 1'b1;
            end
          end
        end
      end
      CMD_STOP: drop_nav();
      default: ;
    endcase
    r.act = nav_on;
    r.tx  = nav_on ? aim_x : '0;
    r.ty  = nav_on ? aim_y : '0;
    r.tz  = nav_on ? aim_z : '0;
    r.idx = nav_on ? wp_idx : WPIDX_NONE;
    return r;
  endfunction

  function automatic script_row_t step_row(logic [CMD_W-1:0] c, logic [3:0] s,
                                           pos_t x, pos_t y, pos_t z);
    script_row_t row;
    row         = '{default: '0};
    row.cmd     = c;
    row.item    = {z, y, x, s};
    return row;
  endfunction

  function automatic script_row_t lit_row(logic [CMD_W-1:0] c, logic [3:0] s,
                                          pos_t x, pos_t y, pos_t z, nav_result_t e);
    script_row_t row;
    row         = step_row(c, s, x, y, z);
    row.has_lit = 1'b1;
    row.lit     = e;
    return row;
  endfunction

  function automatic script_row_t reg_row(logic [CFG_IDX_W-1:0] sel,
                                          logic [CFG_DATA_W-1:0] val);
    script_row_t row;
    row         = '{default: '0};
    row.is_reg  = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    return row;
  endfunction

  function automatic pos_t rand_pos();
    case ($urandom_range(0, 7))
      0: return MIN_POS;
      1: return MAX_POS;
      default: return pos_t'($urandom);
    endcase
  endfunction

  function automatic pos_t near_coord(pos_t c);
    int half;
    half = cfg_radius / 2;
    return pos_t'(int'(c) + int'($urandom_range(0, 2 * half)) - half);
  endfunction

  task automatic check_field(string name, logic signed [63:0] e, logic signed [63:0] a);
    if (a !== e) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      errors++;
    end
  endtask

  // hold the input side idle until every result is back and the block settles
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_navs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (sel)
      REG_RADIUS:  cfg_radius = val[15:0];
      REG_CLIMB:   cfg_climb  = val;
      REG_REQ:     cfg_req    = val[0];
      REG_PLANLEN: cfg_len    = val[4:0];
      default: ;
    endcase
  endtask

  task automatic send_nav(logic [CMD_W-1:0] c, nav_item_t it, logic use_lit,
                          nav_result_t lit);
    int          gap;
    nav_result_t want;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, it};
    s_tuser  <= c;
    do @(posedge clk); while (!s_tready);
    want = advance_nav(c, it);
    pending_navs.push_back(use_lit ? lit : want);
    items_sent++;
  endtask

  task automatic random_item();
    int               k;
    logic [CMD_W-1:0] c;
    nav_item_t        it;
    k       = $urandom_range(0, 99);
    it.slot = 4'($urandom_range(0, 15));
    it.x    = rand_pos();
    it.y    = rand_pos();
    it.z    = rand_pos();
    if (nav_on) begin
      if (k < 60) begin
        c    = CMD_POS;
        it.x = near_coord(aim_x);
        it.y = near_coord(aim_y);
        it.z = near_coord(aim_z);
      end else if (k < 68) begin
        // one axis exactly on the radius
        c    = CMD_POS;
        it.x = $urandom_range(0, 1) ? pos_t'(int'(aim_x) + int'(cfg_radius))
                                    : pos_t'(int'(aim_x) - int'(cfg_radius));
        it.y = aim_y;
        it.z = aim_z;
      end else if (k < 76) begin
        c = CMD_POS;
      end else if (k < 85) begin
        c = CMD_LOAD;
      end else if (k < 91) begin
        c = CMD_START;
      end else if (k < 95) begin
        c = CMD_STOP;
      end else begin
        c = CMD_W'($urandom_range(0, 3));
      end
    end else begin
      if (k < 50) c = CMD_START;
      else if (k < 70) c = CMD_LOAD;
      else if (k < 85) c = CMD_POS;
      else if (k < 92) c = CMD_STOP;
      else c = CMD_W'($urandom_range(0, 3));
    end
    send_nav(c, it, 1'b0, '0);
  endtask

  task automatic configure_phase();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = 65535;
      2: v = 1;
      3: v = CFG_DATA_W'($urandom_range(0, 65535));
      default: v = CFG_DATA_W'($urandom_range(2, 3000));
    endcase
    write_reg(REG_RADIUS, v);
    case ($urandom_range(0, 5))
      0: v = MIN_POS;
      1: v = MAX_POS;
      default: v = CFG_DATA_W'($urandom);
    endcase
    write_reg(REG_CLIMB, v);
    write_reg(REG_REQ, CFG_DATA_W'($urandom_range(0, 1)));
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = CFG_DATA_W'($urandom_range(17, 31));
      2: v = 16;
      default: v = CFG_DATA_W'($urandom_range(1, 8));
    endcase
    write_reg(REG_PLANLEN, v);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int          pause;
    nav_result_t got;
    nav_result_t want;
    while (rst) @(posedge clk);
    forever begin
      pause = rx_steady ? 0 : $urandom_range(0, 3);
      if (long_hold) begin
        pause += HOLD_CYCLES;
        long_hold = 1'b0;
      end
      if (pause > 0) begin
        m_tready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = m_tdata[80:0];
      if (pending_navs.size() == 0) begin
        $display("%0t ns: unexpected result transaction, actual %h", $time, got);
        errors++;
      end else begin
        want = pending_navs.pop_front();
        check_field("nav_active", want.act, got.act);
        check_field("target_x", want.tx, got.tx);
        check_field("target_y", want.ty, got.ty);
        check_field("target_z", want.tz, got.tz);
        check_field("waypoint_index", want.idx, got.idx);
        check_field("reset_integral", want.rint, got.rint);
        check_field("plan_complete", want.done, got.done);
        check_field("start_failed", want.fail, got.fail);
      end
    end
  end

  initial begin
    int        n;
    int        phase;
    nav_item_t it;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    script.push_back(lit_row(CMD_POS, 0, 0, 0, 0, IDLE_NAV));
    script.push_back(lit_row(CMD_START, 0, 0, 0, 0, FAIL_NAV));
    script.push_back(lit_row(CMD_STOP, 15, MAX_POS, MIN_POS, MAX_POS, IDLE_NAV));
    script.push_back(lit_row(CMD_LOAD, 0, 100, -200, 300, IDLE_NAV));
    script.push_back(lit_row(CMD_LOAD, 1, MAX_POS, MAX_POS, MAX_POS, IDLE_NAV));
    script.push_back(lit_row(CMD_LOAD, 2, MIN_POS, MIN_POS, MIN_POS, IDLE_NAV));
    script.push_back(reg_row(REG_PLANLEN, 3));
    script.push_back(lit_row(CMD_START, 0, 5, 6, 7,
                             {3'b000, 5'sd0, 24'sd1000, 24'sd6, 24'sd5, 1'b1}));
    script.push_back(step_row(CMD_POS, 0, 5, 6, 901));
    script.push_back(step_row(CMD_POS, 0, 200, -200, 300));
    // every axis inside, sum of squares just outside
    script.push_back(step_row(CMD_POS, 0, 158, -142, 358));
    script.push_back(step_row(CMD_LOAD, 0, 1, 2, 3));
    script.push_back(step_row(CMD_POS, 0, 100, -200, 300));
    script.push_back(step_row(CMD_POS, 0, MAX_POS, MAX_POS, MAX_POS));
    script.push_back(lit_row(CMD_POS, 0, MIN_POS, MIN_POS, MIN_POS, DONE_NAV));
    script.push_back(reg_row(REG_REQ, 0));
    script.push_back(step_row(CMD_START, 0, 9, 9, 9));
    script.push_back(step_row(CMD_START, 0, 0, 0, 0));
    script.push_back(lit_row(CMD_STOP, 0, 0, 0, 0, IDLE_NAV));
    script.push_back(reg_row(REG_RADIUS, 0));
    script.push_back(step_row(CMD_START, 0, 0, 0, 0));
    script.push_back(step_row(CMD_POS, 0, 1, 2, 3));
    script.push_back(reg_row(REG_RADIUS, 65535));
    script.push_back(reg_row(REG_PLANLEN, 31));
    script.push_back(step_row(CMD_START, 0, 0, 0, 0));
    script.push_back(lit_row(CMD_STOP, 0, 0, 0, 0, IDLE_NAV));
    script.push_back(reg_row(REG_REQ, 1));
    script.push_back(reg_row(REG_PLANLEN, 2));
    script.push_back(reg_row(REG_CLIMB, MIN_POS));
    script.push_back(step_row(CMD_START, 0, 7, 7, 7));
    // plan emptied during the climb
    script.push_back(reg_row(REG_PLANLEN, 0));
    script.push_back(lit_row(CMD_POS, 0, 7, 7, MIN_POS, IDLE_NAV));
    script.push_back(reg_row(REG_PLANLEN, 2));
    script.push_back(reg_row(REG_CLIMB, MAX_POS));
    script.push_back(step_row(CMD_START, 0, -5, -5, 0));
    script.push_back(step_row(CMD_POS, 0, -5, -5, MAX_POS));
    // shrink the live length mid-plan
    script.push_back(reg_row(REG_PLANLEN, 1));
    script.push_back(step_row(CMD_POS, 0, 1, 2, 3));

    foreach (script[i]) begin
      if (script[i].is_reg)
        write_reg(script[i].reg_sel, script[i].reg_val);
      else
        send_nav(script[i].cmd, script[i].item, script[i].has_lit, script[i].lit);
    end

    // fill the whole table before any random plan can read it
    for (int s = 0; s < 16; s++) begin
      it.slot = 4'(s);
      it.x    = rand_pos();
      it.y    = rand_pos();
      it.z    = rand_pos();
      send_nav(CMD_LOAD, it, 1'b0, '0);
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      configure_phase();
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        // back up the result side while the input keeps offering
        tx_steady = 1'b1;
        long_hold = 1'b1;
      end
      n = $urandom_range(20, 60);
      for (int i = 0; i < n; i++) begin
        if (i == n / 2 && $urandom_range(0, 2) == 0)
          write_reg(REG_PLANLEN, CFG_DATA_W'($urandom_range(0, 16)));
        random_item();
      end
      phase++;
    end

    drain();
    if (errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

### waypoint_sequencer.f
src/wpseq_pkg.sv
src/wpseq_dist.sv
src/waypoint_sequencer.sv
verif/tb_top.sv
